>>> rtl/core/kncp_pkg.sv
package kncp_pkg;

  // Sizing of the state; TABLE_ENTRIES must be a power of two.
  localparam int MAX_ORDER     = 8;
  localparam int TABLE_ENTRIES = 65536;
  localparam int PROBE_LIMIT   = 128;

  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int CTX_AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int TBL_AW = $clog2(TABLE_ENTRIES);
  localparam int PRB_W  = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W  = 64;
  localparam int CNT_W  = 32;
  localparam int DIV_W  = 47;
  localparam int SUF_W  = 10;
  localparam int BC_AW  = 8;

  localparam logic [KEY_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [KEY_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [SUF_W-1:0] SUF_TOTAL = 10'd512;
  localparam logic [SUF_W-1:0] SUF_TYPES = 10'd513;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic CFG_ORD_CAP   = 1'b0;
  localparam logic CFG_DISCOUNT  = 1'b1;
  localparam logic CMD_TRAIN     = 1'b0;
  localparam logic CMD_EVAL      = 1'b1;

  typedef enum logic [1:0] {TB_CLEAR, TB_IDLE, TB_ISSUE, TB_CMP} tbl_state_e;
  typedef enum logic [0:0] {DV_IDLE, DV_RUN} div_state_e;
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_BRD, ST_BUSE, ST_MARG, ST_HASH,
    ST_TCONT, ST_TTOT, ST_TTYP, ST_ETOT, ST_ECNT, ST_ETYP,
    ST_EPK, ST_ELAM, ST_EMUL, ST_ESUM, ST_OUT
  } st_e;

  typedef struct packed {
    logic             start;
    logic             add;
    logic [KEY_W-1:0] key;
  } tbl_req_t;

  typedef struct packed {
    logic             done;
    logic             ready;
    logic [CNT_W-1:0] count;
  } tbl_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == CNT_MAX) ? x : x + 1'b1;
  endfunction

  // One FNV-1a step; the prime is 2^40 + 2^8 + 0xb3.
  function automatic logic [KEY_W-1:0] fnv_step(input logic [KEY_W-1:0] h,
                                                input logic [7:0] b);
    logic [KEY_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x * 64'd179);
  endfunction

  function automatic logic [KEY_W-1:0] make_key(input logic [KEY_W-1:0] h,
                                                input logic [SUF_W-1:0] suf);
    logic [KEY_W-1:0] m;
    m = {{(KEY_W-SUF_W){1'b0}}, suf} * GOLDEN;
    return (h ^ m) | 64'd1;
  endfunction

endpackage

>>> rtl/core/kn_ngram_count_and_predict.sv
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   cmd_i, data_byte_i
// out       output     out_valid_o / out_stall_i probability_o, orders_used_o
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word at a time; in_stall_o stays high from acceptance until idle again.
// A table lookup probes one row after another until a hit, an empty row or
// the probe limit; a divide ends early when the quotient saturates. Train:
// per order two or three lookups. Evaluate: a marginal divide, then per order
// a lookup, and for a used order two more lookups and up to two divides.
// After reset the 65536-row table is cleared one row a cycle with in_stall_o
// high. A stalled result keeps the block from finishing the next evaluate.
module kn_ngram_count_and_predict (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] probability_o,
  output logic [3:0]  orders_used_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import kncp_pkg::*;

  st_e               state_q, state_d;
  logic [3:0]        ord_cap_q;
  logic [12:0]       disc_q;
  logic [7:0]        ctx_q [MAX_ORDER];
  logic [7:0]        ctx_d [MAX_ORDER];
  logic [ORD_W-1:0]  seen_q, seen_d, top_q, top_d, ord_q, ord_d, hi_q, hi_d;
  logic              cmd_q, cmd_d;
  logic [7:0]        byte_q, byte_d;
  logic [KEY_W-1:0]  h_q, h_d;
  logic              pend_q, pend_d, pzero_q, pzero_d;
  logic [CNT_W-1:0]  tt_q, tt_d, tc_q, tc_d, c_q, c_d, ty_q, ty_d;
  logic [CNT_W-1:0]  pk_q, pk_d, lam_q, lam_d, p_q, p_d;
  logic [63:0]       prod_q, prod_d;
  logic [3:0]        used_q, used_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       prob_q, prob_d;
  logic [3:0]        oused_q, oused_d;
  logic [BC_AW-1:0]  bclr_q, bclr_d;
  logic              bclr_done_q, bclr_done_d;

  tbl_req_t          treq;
  tbl_rsp_t          trsp;
  div_req_t          dreq;
  div_rsp_t          drsp;
  logic [SUF_W-1:0]  suf;

  logic              bwe, bre;
  logic [BC_AW-1:0]  bwaddr;
  logic [CNT_W-1:0]  bwdata, brdata;

  logic [ORD_W:0]    mo_ext, eff_ext;
  logic [ORD_W-1:0]  eff;
  logic [43:0]       cnum, tden;
  logic [32:0]       psum;
  logic              accept;

  kncp_table u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (treq),
    .rsp_o (trsp)
  );

  kncp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  kncp_ram #(.Width(CNT_W), .Depth(256)) u_bcnt (
    .clk_i  (clk_i),
    .we_i   (bwe),
    .waddr_i(bwaddr),
    .wdata_i(bwdata),
    .re_i   (bre),
    .raddr_i(byte_q),
    .rdata_o(brdata)
  );

  // Take a register write whenever cfg_we_i is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_cap_q <= 4'd6;
      disc_q    <= 13'd3277;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORD_CAP:  ord_cap_q <= cfg_data_i[3:0];
        CFG_DISCOUNT: disc_q    <= cfg_data_i;
        default:      ord_cap_q <= ord_cap_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      for (int k = 0; k < MAX_ORDER; k++) ctx_q[k] <= '0;
      seen_q      <= '0;
      top_q       <= '0;
      ord_q       <= '0;
      hi_q        <= '0;
      cmd_q       <= 1'b0;
      byte_q      <= '0;
      h_q         <= '0;
      pend_q      <= 1'b0;
      pzero_q     <= 1'b0;
      tt_q        <= '0;
      tc_q        <= '0;
      c_q         <= '0;
      ty_q        <= '0;
      pk_q        <= '0;
      lam_q       <= '0;
      p_q         <= '0;
      prod_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      prob_q      <= '0;
      oused_q     <= '0;
      bclr_q      <= '0;
      bclr_done_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      seen_q      <= seen_d;
      top_q       <= top_d;
      ord_q       <= ord_d;
      hi_q        <= hi_d;
      cmd_q       <= cmd_d;
      byte_q      <= byte_d;
      h_q         <= h_d;
      pend_q      <= pend_d;
      pzero_q     <= pzero_d;
      tt_q        <= tt_d;
      tc_q        <= tc_d;
      c_q         <= c_d;
      ty_q        <= ty_d;
      pk_q        <= pk_d;
      lam_q       <= lam_d;
      p_q         <= p_d;
      prod_q      <= prod_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      prob_q      <= prob_d;
      oused_q     <= oused_d;
      bclr_q      <= bclr_d;
      bclr_done_q <= bclr_done_d;
    end
  end

  // Effective order: min(order cap, MAX_ORDER, bytes seen).
  always_comb begin
    mo_ext  = (ord_cap_q > 4'(MAX_ORDER)) ? (ORD_W+1)'(MAX_ORDER)
                                            : (ORD_W+1)'(ord_cap_q);
    eff_ext = (mo_ext > (ORD_W+1)'(seen_q)) ? (ORD_W+1)'(seen_q) : mo_ext;
    eff     = eff_ext[ORD_W-1:0];
  end

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign cnum   = {c_q, 12'd0};
  assign tden   = {tc_q, 12'd0};
  assign psum   = {1'b0, pk_q} + {1'b0, prod_q[63:32]};

  always_comb begin
    unique case (state_q)
      ST_TTOT, ST_ETOT: suf = SUF_TOTAL;
      ST_TTYP, ST_ETYP: suf = SUF_TYPES;
      default:          suf = {2'b01, byte_q};
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    seen_d      = seen_q;
    top_d       = top_q;
    ord_d       = ord_q;
    hi_d        = hi_q;
    cmd_d       = cmd_q;
    byte_d      = byte_q;
    h_d         = h_q;
    pend_d      = pend_q;
    pzero_d     = pzero_q;
    tt_d        = tt_q;
    tc_d        = tc_q;
    c_d         = c_q;
    ty_d        = ty_q;
    pk_d        = pk_q;
    lam_d       = lam_q;
    p_d         = p_q;
    prod_d      = prod_q;
    used_d      = used_q;
    out_valid_d = out_valid_q && out_stall_i;
    prob_d      = prob_q;
    oused_d     = oused_q;
    bclr_d      = bclr_q;
    bclr_done_d = bclr_done_q;
    treq.start  = 1'b0;
    treq.add    = (state_q == ST_TCONT) || (state_q == ST_TTOT) ||
                  (state_q == ST_TTYP);
    treq.key    = make_key(h_q, suf);
    dreq.start  = 1'b0;
    dreq.num    = '0;
    dreq.den    = '0;
    bwe         = 1'b0;
    bwaddr      = byte_q;
    bwdata      = sat_inc(brdata);
    bre         = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        if (!bclr_done_q) begin
          bwe    = 1'b1;
          bwaddr = bclr_q;
          bwdata = '0;
          bclr_d = bclr_q + 1'b1;
          if (bclr_q == '1) bclr_done_d = 1'b1;
        end
        if (bclr_done_q && trsp.ready) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_i;
          byte_d = data_byte_i;
          top_d  = eff;
          ord_d  = ORD_W'(1);
          hi_d   = ORD_W'(1);
          h_d    = FNV_BASIS;
          if (cmd_i == CMD_TRAIN && eff != '0) state_d = ST_HASH;
          else                                  state_d = ST_BRD;
        end
      end
      ST_HASH: begin
        h_d  = fnv_step(h_q, ctx_q[CTX_AW'(hi_q - 1'b1)]);
        hi_d = hi_q - 1'b1;
        if (hi_q == ORD_W'(1)) state_d = (cmd_q == CMD_TRAIN) ? ST_TCONT : ST_ETOT;
      end
      ST_TCONT, ST_TTOT, ST_TTYP, ST_ETOT, ST_ECNT, ST_ETYP: begin
        if (!pend_q) begin
          treq.start = 1'b1;
          pend_d     = 1'b1;
        end else if (trsp.done) begin
          pend_d = 1'b0;
          unique case (state_q)
            ST_TCONT: begin
              pzero_d = (trsp.count == '0);
              state_d = ST_TTOT;
            end
            ST_TTOT:  state_d = pzero_q ? ST_TTYP : ST_ESUM;
            ST_TTYP:  state_d = ST_ESUM;
            ST_ETOT: begin
              tc_d    = trsp.count;
              state_d = (trsp.count < CNT_W'(2)) ? ST_ESUM : ST_ECNT;
            end
            ST_ECNT: begin
              c_d     = trsp.count;
              state_d = ST_ETYP;
            end
            default: begin
              ty_d    = (trsp.count == '0) ? CNT_W'(1) : trsp.count;
              state_d = ST_EPK;
            end
          endcase
        end
      end
      ST_EPK: begin
        if (cnum <= 44'(disc_q)) begin
          pk_d    = '0;
          state_d = ST_ELAM;
        end else if (!pend_q) begin
          dreq.start = 1'b1;
          dreq.num   = DIV_W'(cnum - 44'(disc_q));
          dreq.den   = DIV_W'(tden);
          pend_d     = 1'b1;
        end else if (drsp.done) begin
          pend_d  = 1'b0;
          pk_d    = drsp.quo;
          state_d = ST_ELAM;
        end
      end
      ST_ELAM: begin
        if (!pend_q) begin
          dreq.start = 1'b1;
          dreq.num   = DIV_W'(45'(disc_q) * 45'(ty_q));
          dreq.den   = DIV_W'(tden);
          pend_d     = 1'b1;
        end else if (drsp.done) begin
          pend_d  = 1'b0;
          lam_d   = drsp.quo;
          state_d = ST_EMUL;
        end
      end
      ST_EMUL: begin
        prod_d  = 64'(lam_q) * 64'(p_q);
        state_d = ST_EMUL == state_q ? ST_ESUM : state_q;
        pk_d    = pk_q;
        pzero_d = 1'b1;
      end
      ST_ESUM: begin
        // Train reaches here to close an order; evaluate folds the term in,
        // unless this order was skipped for a total below two.
        if (cmd_q == CMD_EVAL && pzero_q) begin
          p_d    = psum[32] ? CNT_MAX : psum[31:0];
          used_d = (used_q == 4'hf) ? used_q : used_q + 1'b1;
        end
        pzero_d = 1'b0;
        if (ord_q == top_q) begin
          state_d = (cmd_q == CMD_TRAIN) ? ST_BRD : ST_OUT;
        end else begin
          ord_d   = ord_q + 1'b1;
          hi_d    = ord_q + 1'b1;
          h_d     = FNV_BASIS;
          state_d = ST_HASH;
        end
      end
      ST_BRD: begin
        bre     = 1'b1;
        state_d = (cmd_q == CMD_TRAIN) ? ST_BUSE : ST_MARG;
      end
      ST_BUSE: begin
        bwe    = 1'b1;
        tt_d   = sat_inc(tt_q);
        ctx_d[0] = byte_q;
        for (int k = 1; k < MAX_ORDER; k++) ctx_d[k] = ctx_q[k-1];
        if (seen_q != ORD_W'(MAX_ORDER)) seen_d = seen_q + 1'b1;
        state_d = ST_IDLE;
      end
      ST_MARG: begin
        if (!pend_q) begin
          dreq.start = 1'b1;
          dreq.num   = DIV_W'({brdata, 1'b1});
          dreq.den   = DIV_W'({tt_q, 1'b0}) + DIV_W'(256);
          pend_d     = 1'b1;
        end else if (drsp.done) begin
          pend_d  = 1'b0;
          p_d     = drsp.quo;
          used_d  = '0;
          pzero_d = 1'b0;
          state_d = (top_q == '0) ? ST_OUT : ST_HASH;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          prob_d      = (p_q == '0) ? 32'd1 : p_q;
          oused_d     = used_q;
          ctx_d[0]    = byte_q;
          for (int k = 1; k < MAX_ORDER; k++) ctx_d[k] = ctx_q[k-1];
          if (seen_q != ORD_W'(MAX_ORDER)) seen_d = seen_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign probability_o = prob_q;
  assign orders_used_o = oused_q;
endmodule

>>> rtl/core/kncp_ram.sv
module kncp_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

>>> rtl/core/kncp_div.sv
module kncp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kncp_pkg::div_req_t req_i,
  output kncp_pkg::div_rsp_t rsp_o
);
  import kncp_pkg::*;

  div_state_e       state_q, state_d;
  logic [DIV_W-1:0] r_q, r_d, den_q, den_d, r2;
  logic [CNT_W-1:0] q_q, q_d;
  logic [4:0]       n_q, n_d;
  logic             done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      r_q     <= '0;
      den_q   <= '0;
      q_q     <= '0;
      n_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      den_q   <= den_d;
      q_q     <= q_d;
      n_q     <= n_d;
      done_q  <= done_d;
    end
  end

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    den_d   = den_q;
    q_d     = q_q;
    n_d     = n_q;
    done_d  = 1'b0;
    r2      = r_q << 1;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          den_d = req_i.den;
          if (req_i.den == '0 || req_i.num >= req_i.den) begin
            q_d    = CNT_MAX;
            done_d = 1'b1;
          end else begin
            r_d     = req_i.num;
            q_d     = '0;
            n_d     = '0;
            state_d = DV_RUN;
          end
        end
      end
      DV_RUN: begin
        if (r2 >= den_q) begin
          r_d = r2 - den_q;
          q_d = {q_q[CNT_W-2:0], 1'b1};
        end else begin
          r_d = r2;
          q_d = {q_q[CNT_W-2:0], 1'b0};
        end
        n_d = n_q + 1'b1;
        if (n_q == 5'd31) begin
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = q_q;
endmodule

>>> rtl/core/kncp_table.sv
module kncp_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kncp_pkg::tbl_req_t req_i,
  output kncp_pkg::tbl_rsp_t rsp_o
);
  import kncp_pkg::*;

  localparam int RowW = KEY_W + CNT_W;

  tbl_state_e       state_q, state_d;
  logic [TBL_AW-1:0] idx_q, idx_d, clr_q, clr_d;
  logic [PRB_W-1:0]  prb_q, prb_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              add_q, add_d, done_q, done_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              we, re;
  logic [TBL_AW-1:0] waddr;
  logic [RowW-1:0]   wdata, rdata;
  logic [KEY_W-1:0]  rkey;
  logic [CNT_W-1:0]  rcnt;
  logic              hit, empty;

  kncp_ram #(.Width(RowW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TB_CLEAR;
      idx_q   <= '0;
      clr_q   <= '0;
      prb_q   <= '0;
      key_q   <= '0;
      add_q   <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      clr_q   <= clr_d;
      prb_q   <= prb_d;
      key_q   <= key_d;
      add_q   <= add_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  assign rkey  = rdata[RowW-1:CNT_W];
  assign rcnt  = rdata[CNT_W-1:0];
  assign hit   = (rkey == key_q);
  assign empty = (rkey == '0);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    clr_d   = clr_q;
    prb_d   = prb_q;
    key_d   = key_q;
    add_d   = add_q;
    done_d  = 1'b0;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = idx_q;
    wdata   = '0;
    unique case (state_q)
      TB_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == TBL_AW'(TABLE_ENTRIES - 1)) begin
          state_d = TB_IDLE;
        end
      end
      TB_IDLE: begin
        if (req_i.start) begin
          key_d   = req_i.key;
          add_d   = req_i.add;
          idx_d   = req_i.key[TBL_AW+2:3];
          prb_d   = '0;
          state_d = TB_ISSUE;
        end
      end
      TB_ISSUE: begin
        re      = 1'b1;
        state_d = TB_CMP;
      end
      TB_CMP: begin
        if (hit || empty) begin
          done_d  = 1'b1;
          count_d = hit ? rcnt : '0;
          we      = add_q;
          wdata   = {key_q, empty ? CNT_W'(1) : sat_inc(rcnt)};
          state_d = TB_IDLE;
        end else if (prb_q == PRB_W'(PROBE_LIMIT - 1)) begin
          // Window exhausted: read as zero, drop the insert.
          done_d  = 1'b1;
          count_d = '0;
          state_d = TB_IDLE;
        end else begin
          prb_d   = prb_q + 1'b1;
          idx_d   = (idx_q == TBL_AW'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
          state_d = TB_ISSUE;
        end
      end
      default: state_d = TB_IDLE;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.ready = (state_q != TB_CLEAR);
  assign rsp_o.count = count_q;
endmodule

>>> rtl/core/kncp_chk.sv
module kncp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] probability_o,
  input logic [3:0]  orders_used_o
);
  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probability_o))
    else $error("result word dropped under stall");

  a_prob_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> probability_o != 32'd0)
    else $error("probability below floor");

  a_orders: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> orders_used_o <= 4'd8)
    else $error("orders_used out of range");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");
endmodule

bind kn_ngram_count_and_predict kncp_chk u_kncp_chk (.*);
